FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/btmx_pkg.sv
// ---------------------------------------------------------------------------
// btmx_pkg
// Shared constants, controller states and command/status bundles.
// ---------------------------------------------------------------------------
package btmx_pkg;

  // Field widths of the request and result channels
  localparam int VAL_W = 31;
  // Path register covers the widest trie depth
  localparam int PATH_W = 32;
  localparam int PATH_IDX_W = 5;

  // Default trie depth and node pool size
  localparam int BITS_DEF = 31;
  localparam int NODES_DEF = 4096;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ALLOC,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic start;     // latch a new request
    logic step;      // walk or allocate one level
    logic fresh;     // current node was just allocated, treat as empty
    logic load_out;  // move the result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic skip;          // request finishes without a walk
    logic lvl_last;      // current level is the bottom one
    logic child_missing; // insert: next node on the path is absent
    logic dead_end;      // query: current node has no child at all
    logic is_query;      // request in flight is a query
  } dp_status_t;

endpackage

FILE: rtl/core/btmx_ram.sv
// ---------------------------------------------------------------------------
// btmx_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module btmx_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/btmx_ctrl.sv
// ---------------------------------------------------------------------------
// btmx_ctrl
// Sequencer for the trie walk: accept, walk, allocate, hand off result.
// ---------------------------------------------------------------------------
module btmx_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  btmx_pkg::dp_status_t  status,
  output btmx_pkg::dp_cmd_t     cmd
);

  import btmx_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.skip ? ST_FINISH : ST_WALK;
        end
      end
      ST_WALK: begin
        if (status.is_query) begin
          if (status.dead_end || status.lvl_last) begin
            state_next = ST_FINISH;
          end
        end else if (status.lvl_last) begin
          state_next = ST_FINISH;
        end else if (status.child_missing) begin
          state_next = ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        if (status.lvl_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      ST_WALK: begin
        cmd.step = 1'b1;
      end
      ST_ALLOC: begin
        cmd.step  = 1'b1;
        cmd.fresh = 1'b1;
      end
      ST_FINISH: begin
        cmd.load_out = !out_valid || !out_stall;
      end
      default: cmd = '0;
    endcase
    out_valid_next = cmd.load_out | (out_valid & out_stall);
  end

endmodule

FILE: rtl/core/btmx_dp.sv
// ---------------------------------------------------------------------------
// btmx_dp
// Trie datapath: node memory, root pointers, path, result and pool count.
// ---------------------------------------------------------------------------
module btmx_dp #(
  parameter int BITS  = btmx_pkg::BITS_DEF,
  parameter int NODES = btmx_pkg::NODES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  btmx_pkg::dp_cmd_t          cmd,
  output btmx_pkg::dp_status_t       status,
  input  logic                       in_mode,
  input  logic [btmx_pkg::VAL_W-1:0] in_value,
  output logic [btmx_pkg::VAL_W-1:0] max_xor,
  output logic                       valid_res,
  output logic                       pool_full
);

  import btmx_pkg::*;

  localparam int IDXW = $clog2(NODES);
  localparam int CNTW = $clog2(NODES + 1);
  localparam int LVLW = (BITS > 1) ? $clog2(BITS) : 1;
  localparam int ENTW = 2 * IDXW;
  localparam logic [CNTW-1:0] USE_LIMIT = CNTW'(NODES - BITS);

  logic              mode_q, mode_q_next;
  logic [PATH_W-1:0] path, path_next;
  logic [LVLW-1:0]   lvl, lvl_next;
  logic [IDXW-1:0]   node, node_next;
  logic [PATH_W-1:0] res, res_next;
  logic              res_valid, res_valid_next;
  logic              res_full, res_full_next;
  logic [CNTW-1:0]   nodes_used, nodes_used_next;
  logic [IDXW-1:0]   root_zero, root_zero_next;
  logic [IDXW-1:0]   root_one, root_one_next;

  logic                  ram_we;
  logic [ENTW-1:0]       ram_wdata;
  logic [ENTW-1:0]       ram_rdata;
  logic [IDXW-1:0]       cur_zero, cur_one;
  logic [PATH_IDX_W-1:0] lvl_idx;
  logic                  bit_b;
  logic [IDXW-1:0]       follow, want, other;
  logic [IDXW-1:0]       new_idx;
  logic                  empty, pool_low;

  btmx_ram #(
    .WIDTH (ENTW),
    .DEPTH (NODES)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (node),
    .wdata (ram_wdata),
    .raddr (node_next),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (cmd.fresh) begin
      cur_zero = '0;
      cur_one  = '0;
    end else if (node == '0) begin
      cur_zero = root_zero;
      cur_one  = root_one;
    end else begin
      cur_zero = ram_rdata[IDXW-1:0];
      cur_one  = ram_rdata[ENTW-1:IDXW];
    end
  end

  assign lvl_idx  = PATH_IDX_W'(lvl);
  assign bit_b    = path[lvl_idx];
  assign follow   = bit_b ? cur_one : cur_zero;
  assign other    = follow;
  assign want     = bit_b ? cur_zero : cur_one;
  assign new_idx  = nodes_used[IDXW-1:0];
  assign empty    = (root_zero == '0) && (root_one == '0);
  assign pool_low = nodes_used > USE_LIMIT;

  always_comb begin
    status.skip          = in_mode ? empty : pool_low;
    status.lvl_last      = (lvl == '0);
    status.child_missing = (follow == '0);
    status.dead_end      = (want == '0) && (other == '0);
    status.is_query      = mode_q;
  end

  always_comb begin
    mode_q_next     = mode_q;
    path_next       = path;
    lvl_next        = lvl;
    node_next       = node;
    res_next        = res;
    res_valid_next  = res_valid;
    res_full_next   = res_full;
    nodes_used_next = nodes_used;
    root_zero_next  = root_zero;
    root_one_next   = root_one;
    ram_we          = 1'b0;
    ram_wdata       = bit_b ? {new_idx, cur_zero} : {cur_one, new_idx};

    if (cmd.start) begin
      mode_q_next    = in_mode;
      path_next      = PATH_W'(in_value);
      lvl_next       = LVLW'(BITS - 1);
      node_next      = '0;
      res_next       = '0;
      res_valid_next = in_mode & ~empty;
      res_full_next  = ~in_mode & pool_low;
    end else if (cmd.step) begin
      lvl_next = lvl - LVLW'(1);
      if (mode_q) begin
        if (want != '0) begin
          res_next[lvl_idx] = 1'b1;
          node_next         = want;
        end else if (other != '0) begin
          node_next = other;
        end
      end else if (follow == '0) begin
        // Hook a new node under the current one and descend into it
        node_next       = new_idx;
        nodes_used_next = nodes_used + CNTW'(1);
        if (node == '0) begin
          if (bit_b) begin
            root_one_next = new_idx;
          end else begin
            root_zero_next = new_idx;
          end
        end else begin
          ram_we = 1'b1;
        end
      end else begin
        node_next = follow;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_used <= CNTW'(1);
      root_zero  <= '0;
      root_one   <= '0;
    end else begin
      nodes_used <= nodes_used_next;
      root_zero  <= root_zero_next;
      root_one   <= root_one_next;
    end
  end

  always_ff @(posedge clk) begin
    mode_q    <= mode_q_next;
    path      <= path_next;
    lvl       <= lvl_next;
    node      <= node_next;
    res       <= res_next;
    res_valid <= res_valid_next;
    res_full  <= res_full_next;
    if (cmd.load_out) begin
      max_xor   <= res[VAL_W-1:0];
      valid_res <= res_valid;
      pool_full <= res_full;
    end
  end

endmodule

FILE: rtl/core/binary_trie_max_xor.sv
// ---------------------------------------------------------------------------
// binary_trie_max_xor
// Binary trie holding 31-bit values, answering maximum-XOR queries.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_stall, mode, value): mode 0 inserts value,
//   mode 1 asks for the largest XOR of value with any stored value.
//   Result channel (out_valid/out_stall, max_xor, valid_res, pool_full):
//   exactly one result per request, in request order.
//   A request walks the trie one level per cycle, since each level needs
//   one node memory read that depends on the previous one. No new request
//   is taken until the previous one has moved its result into the output
//   register. Requests that need no walk (query on an empty trie, refused
//   insert) go from acceptance to the finish state and from there into the
//   output register.
//   An insert is refused whole, with pool_full set, when fewer than BITS
//   nodes are free, even if its path already exists.
//   Reset empties the trie (root pointers cleared, pool count back to one);
//   the node memory itself needs no clearing, entries are written on
//   allocation. A stalled result sits in the output register while the next
//   request is accepted and walked; that walk waits at its end until the
//   output register is free.
// ---------------------------------------------------------------------------
module binary_trie_max_xor #(
  parameter int BITS  = btmx_pkg::BITS_DEF,
  parameter int NODES = btmx_pkg::NODES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       mode,
  input  logic [btmx_pkg::VAL_W-1:0] value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [btmx_pkg::VAL_W-1:0] max_xor,
  output logic                       valid_res,
  output logic                       pool_full
);

  import btmx_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: owns handshakes and the walk state
  btmx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: node memory, path, result and output register
  btmx_dp #(
    .BITS  (BITS),
    .NODES (NODES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_mode   (mode),
    .in_value  (value),
    .max_xor   (max_xor),
    .valid_res (valid_res),
    .pool_full (pool_full)
  );

endmodule

FILE: rtl/core/btmx_checker.sv
// ---------------------------------------------------------------------------
// btmx_checker
// Port-level checks on the trie block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module btmx_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [btmx_pkg::VAL_W-1:0] max_xor,
  input logic                       valid_res,
  input logic                       pool_full
);

  // A stalled result is held
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped")

  // Block stays busy right after taking a request
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "no busy")

  // Query success and refused insert never show together
  `ASSERT_IMPLIES(a_flags_excl, clk, rst, out_valid, !(valid_res && pool_full), "flags clash")

  // Without a query hit the XOR field is zero
  `ASSERT_IMPLIES(a_zero_xor, clk, rst, out_valid && !valid_res, max_xor == '0, "xor not 0")

endmodule

bind binary_trie_max_xor btmx_checker u_btmx_checker (.*);
